// File: src/mmk_pkg.sv
// shared types, constants and tables of the multi-mode keyer
package mmk_pkg;

    localparam int DOT_W  = 16;
    localparam int DUR_W  = 20;
    localparam int CHAR_W = 8;
    localparam int PAT_W  = 9;
    localparam int CNT_W  = 4;
    localparam int CFG_W  = 3;

    localparam logic [DOT_W-1:0]  DOT_MS_RST   = 16'd100;
    localparam logic [DOT_W-1:0]  PAUSE_MS_RST = 16'd1000;
    localparam logic [CHAR_W-1:0] HEX_SW_RST   = 8'd35;
    localparam logic [CHAR_W-1:0] UNARY_SW_RST = 8'd36;
    localparam logic [CHAR_W-1:0] CHESS_SW_RST = 8'd37;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UNDER = 8'h5F;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    localparam logic [CFG_W-1:0] CFG_DOT_MS   = 3'd0;
    localparam logic [CFG_W-1:0] CFG_PAUSE_MS = 3'd1;
    localparam logic [CFG_W-1:0] CFG_HEX_SW   = 3'd2;
    localparam logic [CFG_W-1:0] CFG_UNARY_SW = 3'd3;
    localparam logic [CFG_W-1:0] CFG_CHESS_SW = 3'd4;

    typedef enum logic [1:0] {
        KIND_GAP  = 2'd0,
        KIND_KEY  = 2'd1,
        KIND_LAMP = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_MORSE = 2'd0,
        MODE_HEX   = 2'd1,
        MODE_UNARY = 2'd2,
        MODE_CHESS = 2'd3
    } mode_t;

    // segment length as a multiple of the dot
    typedef enum logic [2:0] {
        MUL_NONE = 3'd0,
        MUL_1    = 3'd1,
        MUL_2    = 3'd2,
        MUL_3    = 3'd3,
        MUL_6    = 3'd4,
        MUL_12   = 3'd5
    } mul_t;

    typedef enum logic [2:0] {
        SEQ_IDLE     = 3'd0,
        SEQ_HEAD     = 3'd1,
        SEQ_LAMP_ON  = 3'd2,
        SEQ_LAMP_GAP = 3'd3,
        SEQ_KEY      = 3'd4,
        SEQ_ELEM_GAP = 3'd5,
        SEQ_TAIL     = 3'd6,
        SEQ_PAUSE    = 3'd7
    } seq_state_t;

    // segment program of one character
    typedef struct packed {
        logic             head;
        logic             lamp;
        logic [CNT_W-1:0] cnt;
        logic [PAT_W-1:0] pat;
        mul_t             tail;
        logic             pause;
    } plan_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] len;
        logic [5:0] pat;
    } morse_sym_t;

    // dash is 1, first element in the msb
    function automatic morse_sym_t morse_sym(input logic [CHAR_W-1:0] u);
        morse_sym_t s;
        s = '{valid: 1'b1, len: 3'd0, pat: 6'b0};
        case (u)
            8'h41: begin s.len = 3'd2; s.pat = 6'b010000; end
            8'h42: begin s.len = 3'd4; s.pat = 6'b100000; end
            8'h43: begin s.len = 3'd4; s.pat = 6'b101000; end
            8'h44: begin s.len = 3'd3; s.pat = 6'b100000; end
            8'h45: begin s.len = 3'd1; s.pat = 6'b000000; end
            8'h46: begin s.len = 3'd4; s.pat = 6'b001000; end
            8'h47: begin s.len = 3'd3; s.pat = 6'b110000; end
            8'h48: begin s.len = 3'd4; s.pat = 6'b000000; end
            8'h49: begin s.len = 3'd2; s.pat = 6'b000000; end
            8'h4A: begin s.len = 3'd4; s.pat = 6'b011100; end
            8'h4B: begin s.len = 3'd3; s.pat = 6'b101000; end
            8'h4C: begin s.len = 3'd4; s.pat = 6'b010000; end
            8'h4D: begin s.len = 3'd2; s.pat = 6'b110000; end
            8'h4E: begin s.len = 3'd2; s.pat = 6'b100000; end
            8'h4F: begin s.len = 3'd3; s.pat = 6'b111000; end
            8'h50: begin s.len = 3'd4; s.pat = 6'b011000; end
            8'h51: begin s.len = 3'd4; s.pat = 6'b110100; end
            8'h52: begin s.len = 3'd3; s.pat = 6'b010000; end
            8'h53: begin s.len = 3'd3; s.pat = 6'b000000; end
            8'h54: begin s.len = 3'd1; s.pat = 6'b100000; end
            8'h55: begin s.len = 3'd3; s.pat = 6'b001000; end
            8'h56: begin s.len = 3'd4; s.pat = 6'b000100; end
            8'h57: begin s.len = 3'd3; s.pat = 6'b011000; end
            8'h58: begin s.len = 3'd4; s.pat = 6'b100100; end
            8'h59: begin s.len = 3'd4; s.pat = 6'b101100; end
            8'h5A: begin s.len = 3'd4; s.pat = 6'b110000; end
            8'h30: begin s.len = 3'd5; s.pat = 6'b111110; end
            8'h31: begin s.len = 3'd5; s.pat = 6'b011110; end
            8'h32: begin s.len = 3'd5; s.pat = 6'b001110; end
            8'h33: begin s.len = 3'd5; s.pat = 6'b000110; end
            8'h34: begin s.len = 3'd5; s.pat = 6'b000010; end
            8'h35: begin s.len = 3'd5; s.pat = 6'b000000; end
            8'h36: begin s.len = 3'd5; s.pat = 6'b100000; end
            8'h37: begin s.len = 3'd5; s.pat = 6'b110000; end
            8'h38: begin s.len = 3'd5; s.pat = 6'b111000; end
            8'h39: begin s.len = 3'd5; s.pat = 6'b111100; end
            8'h2E: begin s.len = 3'd6; s.pat = 6'b010101; end
            8'h2C: begin s.len = 3'd6; s.pat = 6'b110011; end
            8'h3F: begin s.len = 3'd6; s.pat = 6'b001100; end
            8'h2F: begin s.len = 3'd5; s.pat = 6'b100100; end
            8'h40: begin s.len = 3'd6; s.pat = 6'b011010; end
            default: s.valid = 1'b0;
        endcase
        return s;
    endfunction

    function automatic seq_state_t after_elems(input plan_t p);
        return (p.tail != MUL_NONE) ? SEQ_TAIL : (p.pause ? SEQ_PAUSE : SEQ_IDLE);
    endfunction

    function automatic seq_state_t after_lamp(input plan_t p);
        return (p.cnt != '0) ? SEQ_KEY : after_elems(p);
    endfunction

    function automatic seq_state_t after_head(input plan_t p);
        return p.lamp ? SEQ_LAMP_ON : after_lamp(p);
    endfunction

    function automatic seq_state_t start_state(input plan_t p);
        return p.head ? SEQ_HEAD : after_head(p);
    endfunction

endpackage

// File: src/mmk_in_if.sv
// character request channel
interface mmk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       first_in_message;
    logic       last_in_message;

    modport source (output valid, output char_code, output first_in_message,
                    output last_in_message, input ready);
    modport sink (input valid, input char_code, input first_in_message,
                  input last_in_message, output ready);
endinterface

// File: src/mmk_out_if.sv
// keying segment request channel
interface mmk_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  segment_kind;
    logic [19:0] duration_ms;
    logic        last_segment;

    modport source (output valid, output segment_kind, output duration_ms,
                    output last_segment, input ready);
    modport sink (input valid, input segment_kind, input duration_ms,
                  input last_segment, output ready);
endinterface

// File: src/morse_multi_mode_keyer_top.sv
// multi-mode keyer top level: config registers, decoder and sequencer
// A character is taken when the sequencer is idle; the sequencer then emits one segment per
// cycle into the output register while the consumer keeps up, and takes no new character
// until it has emitted the last segment of this one. It shifts the element pattern out one
// element per key/gap pair. A character that emits nothing frees the input again the cycle
// after it is taken. Configuration writes go through cfg_we, cfg_index and cfg_data while
// the block is idle; the user must keep to this, as the block does not enforce it.
module morse_multi_mode_keyer_top
    import mmk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    mmk_in_if.sink           chars,
    mmk_out_if.source        segments,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_index,
    input  logic [DOT_W-1:0] cfg_data
);

    logic [DOT_W-1:0]  dot_ms_reg;
    logic [DOT_W-1:0]  pause_ms_reg;
    logic [CHAR_W-1:0] hex_sw_reg;
    logic [CHAR_W-1:0] unary_sw_reg;
    logic [CHAR_W-1:0] chess_sw_reg;
    logic              ready;
    logic              accept;
    plan_t             plan;

    assign chars.ready = ready;
    assign accept      = chars.valid && ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_ms_reg   <= DOT_MS_RST;
            pause_ms_reg <= PAUSE_MS_RST;
            hex_sw_reg   <= HEX_SW_RST;
            unary_sw_reg <= UNARY_SW_RST;
            chess_sw_reg <= CHESS_SW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DOT_MS:   dot_ms_reg   <= cfg_data;
                CFG_PAUSE_MS: pause_ms_reg <= cfg_data;
                CFG_HEX_SW:   hex_sw_reg   <= cfg_data[CHAR_W-1:0];
                CFG_UNARY_SW: unary_sw_reg <= cfg_data[CHAR_W-1:0];
                CFG_CHESS_SW: chess_sw_reg <= cfg_data[CHAR_W-1:0];
                default:      ;
            endcase
        end
    end

    mmk_decoder u_decoder (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .char_code         (chars.char_code),
        .first_in_message  (chars.first_in_message),
        .last_in_message   (chars.last_in_message),
        .hex_switch_char   (hex_sw_reg),
        .unary_switch_char (unary_sw_reg),
        .chess_switch_char (chess_sw_reg),
        .plan              (plan)
    );

    mmk_sequencer u_sequencer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .in_ready (ready),
        .plan_in  (plan),
        .dot_ms   (dot_ms_reg),
        .pause_ms (pause_ms_reg),
        .segments (segments)
    );

endmodule

// File: src/mmk_decoder.sv
// character decoder: mode tracking and segment program per character
module mmk_decoder
    import mmk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              first_in_message,
    input  logic              last_in_message,
    input  logic [CHAR_W-1:0] hex_switch_char,
    input  logic [CHAR_W-1:0] unary_switch_char,
    input  logic [CHAR_W-1:0] chess_switch_char,
    output plan_t             plan
);

    mode_t             mode_reg;
    mode_t             mode_next;
    mode_t             eff_mode;
    logic              is_switch;
    logic [CHAR_W-1:0] u;
    morse_sym_t        sym;

    always_comb
    begin
        u = char_code;
        if (char_code inside {[8'h61:8'h7A]})
        begin
            u = char_code - 8'd32;
        end
    end

    assign sym = morse_sym(u);

    always_comb
    begin
        is_switch = 1'b1;
        mode_next = mode_reg;
        if (char_code == hex_switch_char)
        begin
            mode_next = MODE_HEX;
        end
        else if (char_code == unary_switch_char)
        begin
            mode_next = MODE_UNARY;
        end
        else if (char_code == chess_switch_char)
        begin
            mode_next = MODE_CHESS;
        end
        else if (char_code == CHAR_UNDER)
        begin
            mode_next = MODE_MORSE;
        end
        else
        begin
            is_switch = 1'b0;
            if (first_in_message)
            begin
                mode_next = MODE_MORSE;
            end
        end
    end

    assign eff_mode = mode_next;

    always_comb
    begin
        plan = '{head: 1'b0, lamp: 1'b0, cnt: '0, pat: '0, tail: MUL_NONE,
                 pause: last_in_message};
        if (!is_switch)
        begin
            case (eff_mode)
                MODE_MORSE:
                begin
                    plan.tail = MUL_2;
                    if (u == CHAR_SPACE)
                    begin
                        plan.head = 1'b1;
                    end
                    else if (sym.valid)
                    begin
                        plan.cnt = CNT_W'(sym.len);
                        plan.pat = {sym.pat, 3'b000};
                    end
                    else
                    begin
                        plan.lamp = 1'b1;
                    end
                end
                MODE_HEX:
                begin
                    plan.tail = MUL_6;
                    if (u inside {[8'h30:8'h39]})
                    begin
                        plan.cnt = 4'd4;
                        plan.pat = {u[3:0], 5'b0};
                    end
                    else if (u inside {[8'h41:8'h46]})
                    begin
                        plan.cnt = 4'd4;
                        plan.pat = {u[3:0] + 4'd9, 5'b0};
                    end
                    else if (u != CHAR_SPACE)
                    begin
                        plan.lamp = 1'b1;
                    end
                end
                MODE_UNARY:
                begin
                    plan.tail = MUL_2;
                    if (char_code == CHAR_SPACE)
                    begin
                        plan.tail = MUL_6;
                    end
                    else if (char_code == CHAR_ZERO)
                    begin
                        plan.cnt = 4'd1;
                        plan.pat = {1'b1, 8'b0};
                    end
                    else if (char_code inside {[8'h31:8'h39]})
                    begin
                        plan.cnt = char_code[3:0];
                    end
                    else
                    begin
                        plan.lamp = 1'b1;
                    end
                end
                default:
                begin
                    if (u == CHAR_SPACE)
                    begin
                        plan.tail = MUL_12;
                    end
                    else if (u inside {[8'h41:8'h48]})
                    begin
                        plan.cnt  = u[3:0];
                        plan.tail = MUL_3;
                    end
                    else if (u inside {[8'h31:8'h38]})
                    begin
                        plan.cnt  = u[3:0];
                        plan.tail = MUL_6;
                    end
                    else
                    begin
                        plan.lamp = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MORSE;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

// File: src/mmk_sequencer.sv
// segment sequencer: walks the program, shifting out one element per segment pair
module mmk_sequencer
    import mmk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  plan_t            plan_in,
    input  logic [DOT_W-1:0] dot_ms,
    input  logic [DOT_W-1:0] pause_ms,
    mmk_out_if.source        segments
);

    seq_state_t       state_reg;
    seq_state_t       state_next;
    seq_state_t       follow;
    plan_t            plan_reg;
    plan_t            plan_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    kind_t            kind_reg;
    kind_t            kind_next;
    logic [DUR_W-1:0] dur_reg;
    logic [DUR_W-1:0] dur_next;
    logic             last_reg;
    logic             last_next;
    logic             emit;
    kind_t            seg_kind;
    mul_t             seg_mul;
    logic             seg_pause;
    logic [DUR_W-1:0] t1;
    logic [DUR_W-1:0] t3;
    logic [DUR_W-1:0] seg_dur;

    assign in_ready = (state_reg == SEQ_IDLE);
    assign emit     = (state_reg != SEQ_IDLE) && (!out_valid_reg || segments.ready);

    assign t1 = DUR_W'(dot_ms);
    assign t3 = t1 + (t1 << 1);

    always_comb
    begin
        case (seg_mul)
            MUL_1:   seg_dur = t1;
            MUL_2:   seg_dur = t1 << 1;
            MUL_3:   seg_dur = t3;
            MUL_6:   seg_dur = t3 << 1;
            MUL_12:  seg_dur = t3 << 2;
            default: seg_dur = '0;
        endcase
        if (seg_pause)
        begin
            seg_dur = DUR_W'(pause_ms);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        plan_next      = plan_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        dur_next       = dur_reg;
        last_next      = last_reg;
        seg_kind       = KIND_GAP;
        seg_mul        = MUL_NONE;
        seg_pause      = 1'b0;
        follow         = SEQ_IDLE;

        if (out_valid_reg && segments.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    plan_next  = plan_in;
                    state_next = start_state(plan_in);
                end
            end
            SEQ_HEAD:
            begin
                seg_mul = MUL_6;
                follow  = after_head(plan_reg);
            end
            SEQ_LAMP_ON:
            begin
                seg_kind = KIND_LAMP;
                seg_mul  = MUL_1;
                follow   = SEQ_LAMP_GAP;
            end
            SEQ_LAMP_GAP:
            begin
                seg_mul = MUL_2;
                follow  = after_lamp(plan_reg);
            end
            SEQ_KEY:
            begin
                seg_kind = KIND_KEY;
                seg_mul  = plan_reg.pat[PAT_W-1] ? MUL_3 : MUL_1;
                follow   = SEQ_ELEM_GAP;
            end
            SEQ_ELEM_GAP:
            begin
                seg_mul = MUL_1;
                follow  = (plan_reg.cnt > 4'd1) ? SEQ_KEY : after_elems(plan_reg);
            end
            SEQ_TAIL:
            begin
                seg_mul = plan_reg.tail;
                follow  = plan_reg.pause ? SEQ_PAUSE : SEQ_IDLE;
            end
            SEQ_PAUSE:
            begin
                seg_pause = 1'b1;
                follow    = SEQ_IDLE;
            end
            default:
            begin
                follow = SEQ_IDLE;
            end
        endcase

        if (emit)
        begin
            state_next     = follow;
            out_valid_next = 1'b1;
            kind_next      = seg_kind;
            dur_next       = seg_dur;
            last_next      = (follow == SEQ_IDLE);
            if (state_reg == SEQ_ELEM_GAP)
            begin
                plan_next.pat = plan_reg.pat << 1;
                plan_next.cnt = plan_reg.cnt - 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            out_valid_reg <= 1'b0;
            plan_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            plan_reg      <= plan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        dur_reg  <= dur_next;
        last_reg <= last_next;
    end

    assign segments.valid        = out_valid_reg;
    assign segments.segment_kind = kind_reg;
    assign segments.duration_ms  = dur_reg;
    assign segments.last_segment = last_reg;

`ifndef SYNTHESIS
    a_key_then_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && state_reg == SEQ_KEY) |=> (state_reg == SEQ_ELEM_GAP))
        else $error("key segment not followed by element gap");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && follow == SEQ_IDLE) |=> (in_ready && segments.last_segment))
        else $error("final segment without return to idle");

    a_key_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_KEY || state_reg == SEQ_ELEM_GAP) |-> (plan_reg.cnt != '0))
        else $error("element phase with empty count");

    a_tail_present: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_TAIL) |-> (plan_reg.tail != MUL_NONE))
        else $error("tail phase without tail gap");
`endif

endmodule
